### rtl/fcac_pkg.sv
// ----------------------------------------------------------------------------
// fcac_pkg
// Shared types and constants for the framed command actuator controller:
// transfer payloads, queue entries, frame phases and command codes.
// ----------------------------------------------------------------------------
package fcac_pkg;

   // pwm counter period and derived widths
   localparam int PWM_PERIOD = 255;
   localparam int TICK_W     = (PWM_PERIOD > 2) ? $clog2(PWM_PERIOD) : 1;
   localparam int PUMP_W     = 8;
   localparam int GATE_CMP_W = (TICK_W > PUMP_W) ? TICK_W : PUMP_W;

   // decoupling queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_BASE_SPEED = 3'd0,
      REG_ARM_STRIDE = 3'd1,
      REG_PUMP_STEP  = 3'd2,
      REG_SERVO_LOW  = 3'd3,
      REG_SERVO_HIGH = 3'd4
   } reg_index_type;

   // register reset values
   localparam logic [7:0] BASE_SPEED_RESET = 8'd35;
   localparam logic [7:0] ARM_STRIDE_RESET = 8'd10;
   localparam logic [7:0] PUMP_STEP_RESET  = 8'd25;
   localparam logic [9:0] SERVO_LOW_RESET  = 10'd52;
   localparam logic [9:0] SERVO_HIGH_RESET = 10'd256;

   // actuator state reset values and limits
   localparam logic [9:0]        SERVO_RESET = 10'd154;
   localparam logic [PUMP_W-1:0] PUMP_MAX    = 8'd255;

   // frame bytes
   localparam logic [7:0] BYTE_OPEN  = 8'h28;
   localparam logic [7:0] BYTE_CLOSE = 8'h29;

   // command bytes
   localparam logic [7:0] CMD_FORWARD    = 8'h41;
   localparam logic [7:0] CMD_BACKWARD   = 8'h42;
   localparam logic [7:0] CMD_LEFT       = 8'h43;
   localparam logic [7:0] CMD_RIGHT      = 8'h44;
   localparam logic [7:0] CMD_SERVO_UP   = 8'h45;
   localparam logic [7:0] CMD_SERVO_DOWN = 8'h46;
   localparam logic [7:0] CMD_PUMP_UP    = 8'h47;
   localparam logic [7:0] CMD_PUMP_DOWN  = 8'h48;
   localparam logic [7:0] CMD_STOP       = 8'h4D;

   // bridge drive patterns
   localparam logic [7:0] PAT_FORWARD  = 8'h05;
   localparam logic [7:0] PAT_BACKWARD = 8'h0A;
   localparam logic [7:0] PAT_LEFT     = 8'h02;
   localparam logic [7:0] PAT_RIGHT    = 8'h04;
   localparam logic [7:0] PAT_STOP     = 8'h00;

   // frame parser phase
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_CMD  = 2'd1,
      PH_TERM = 2'd2
   } phase_type;

   // classified action handed from front to back
   typedef enum logic [2:0] {
      ACT_NONE       = 3'd0,
      ACT_TICK       = 3'd1,
      ACT_BRIDGE     = 3'd2,
      ACT_SERVO_UP   = 3'd3,
      ACT_SERVO_DOWN = 3'd4,
      ACT_PUMP_UP    = 3'd5,
      ACT_PUMP_DOWN  = 3'd6,
      ACT_UNKNOWN    = 3'd7
   } act_type;

   typedef struct packed {
      act_type    act;
      logic [7:0] pattern;
   } entry_type;

   typedef struct packed {
      logic [7:0] arm_stride;
      logic [7:0] pump_step;
      logic [9:0] servo_low;
      logic [9:0] servo_high;
   } cfg_type;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]        bridge_pattern;
      logic [9:0]        servo_duty;
      logic [PUMP_W-1:0] pump_level;
      logic              pump_gate;
      logic              frame_executed;
   } rsp_type;

endpackage

### rtl/fcac_csr.sv
// ----------------------------------------------------------------------------
// fcac_csr
// Configuration registers behind an apb-style port; write on access phase,
// combinational read data, always ready.
// ----------------------------------------------------------------------------
module fcac_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fcac_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fcac_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fcac_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output fcac_pkg::cfg_type                 cfg
);
   import fcac_pkg::*;

   logic [7:0] base_speed_ff, base_speed_in;
   logic [7:0] arm_stride_ff, arm_stride_in;
   logic [7:0] pump_step_ff,  pump_step_in;
   logic [9:0] servo_low_ff,  servo_low_in;
   logic [9:0] servo_high_ff, servo_high_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];

   // register write decode
   always_comb begin
      base_speed_in = base_speed_ff;
      arm_stride_in = arm_stride_ff;
      pump_step_in  = pump_step_ff;
      servo_low_in  = servo_low_ff;
      servo_high_in = servo_high_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_BASE_SPEED: base_speed_in = pwdata[7:0];
            REG_ARM_STRIDE: arm_stride_in = pwdata[7:0];
            REG_PUMP_STEP:  pump_step_in  = pwdata[7:0];
            REG_SERVO_LOW:  servo_low_in  = pwdata[9:0];
            REG_SERVO_HIGH: servo_high_in = pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_speed_ff <= BASE_SPEED_RESET;
         arm_stride_ff <= ARM_STRIDE_RESET;
         pump_step_ff  <= PUMP_STEP_RESET;
         servo_low_ff  <= SERVO_LOW_RESET;
         servo_high_ff <= SERVO_HIGH_RESET;
      end else begin
         base_speed_ff <= base_speed_in;
         arm_stride_ff <= arm_stride_in;
         pump_step_ff  <= pump_step_in;
         servo_low_ff  <= servo_low_in;
         servo_high_ff <= servo_high_in;
      end
   end

   // read mux
   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_BASE_SPEED: prdata = CSR_DATA_W'(base_speed_ff);
         REG_ARM_STRIDE: prdata = CSR_DATA_W'(arm_stride_ff);
         REG_PUMP_STEP:  prdata = CSR_DATA_W'(pump_step_ff);
         REG_SERVO_LOW:  prdata = CSR_DATA_W'(servo_low_ff);
         REG_SERVO_HIGH: prdata = CSR_DATA_W'(servo_high_ff);
         default:        prdata = '0;
      endcase
   end

   assign cfg.arm_stride = arm_stride_ff;
   assign cfg.pump_step  = pump_step_ff;
   assign cfg.servo_low  = servo_low_ff;
   assign cfg.servo_high = servo_high_ff;

endmodule

### rtl/fcac_front.sv
// ----------------------------------------------------------------------------
// fcac_front
// Frame parser: accepts input transfers, tracks the frame phase and turns
// each item into one classified action for the back end.
// ----------------------------------------------------------------------------
module fcac_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fcac_pkg::req_type    req_data,
   input  logic                 queue_full,
   output logic                 push,
   output fcac_pkg::entry_type  entry
);
   import fcac_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_cmd_ff, held_cmd_in;
   logic       accept;
   logic       is_byte;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~queue_full;
   assign is_byte   = accept & ~req_data.command;

   // next frame phase and held command
   always_comb begin
      phase_in    = phase_ff;
      held_cmd_in = held_cmd_ff;
      if (is_byte) begin
         unique case (phase_ff)
            PH_IDLE: phase_in = (req_data.rx_byte == BYTE_OPEN) ? PH_CMD : PH_IDLE;
            PH_CMD: begin
               if (req_data.rx_byte == BYTE_CLOSE) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in    = PH_TERM;
                  held_cmd_in = req_data.rx_byte;
               end
            end
            PH_TERM: phase_in = PH_IDLE;
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         held_cmd_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         held_cmd_ff <= held_cmd_in;
      end
   end

   // classify the item
   always_comb begin
      push          = accept;
      entry.act     = ACT_NONE;
      entry.pattern = PAT_STOP;
      if (req_data.command) begin
         entry.act = ACT_TICK;
      end else if (phase_ff == PH_TERM) begin
         unique case (held_cmd_ff)
            CMD_FORWARD: begin
               entry.act     = ACT_BRIDGE;
               entry.pattern = PAT_FORWARD;
            end
            CMD_BACKWARD: begin
               entry.act     = ACT_BRIDGE;
               entry.pattern = PAT_BACKWARD;
            end
            CMD_LEFT: begin
               entry.act     = ACT_BRIDGE;
               entry.pattern = PAT_LEFT;
            end
            CMD_RIGHT: begin
               entry.act     = ACT_BRIDGE;
               entry.pattern = PAT_RIGHT;
            end
            CMD_STOP: begin
               entry.act     = ACT_BRIDGE;
               entry.pattern = PAT_STOP;
            end
            CMD_SERVO_UP:   entry.act = ACT_SERVO_UP;
            CMD_SERVO_DOWN: entry.act = ACT_SERVO_DOWN;
            CMD_PUMP_UP:    entry.act = ACT_PUMP_UP;
            CMD_PUMP_DOWN:  entry.act = ACT_PUMP_DOWN;
            default:        entry.act = ACT_UNKNOWN;
         endcase
      end
   end

endmodule

### rtl/fcac_queue.sv
// ----------------------------------------------------------------------------
// fcac_queue
// Short queue of classified actions between the front and back ends.
// ----------------------------------------------------------------------------
module fcac_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fcac_pkg::entry_type  push_entry,
   input  logic                 pop,
   output fcac_pkg::entry_type  head,
   output logic                 empty,
   output logic                 full
);
   import fcac_pkg::*;

   entry_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // fill count bounded by depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   // no pop from an empty queue, no push into a full one
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue push while full");

   // push without pop grows the count by one
   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");

endmodule

### rtl/fcac_back.sv
// ----------------------------------------------------------------------------
// fcac_back
// Actuator back end: applies queued actions to the bridge, servo, pump and
// pwm counter state and holds the result in an output register.
// ----------------------------------------------------------------------------
module fcac_back (
   input  logic                 clock,
   input  logic                 reset,
   input  fcac_pkg::cfg_type    cfg,
   input  fcac_pkg::entry_type  head,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fcac_pkg::rsp_type    rsp_data
);
   import fcac_pkg::*;

   logic [7:0]        drive_ff, drive_in;
   logic [9:0]        servo_ff, servo_in;
   logic [PUMP_W-1:0] pump_ff,  pump_in;
   logic [TICK_W-1:0] tick_ff,  tick_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              executed;
   logic [10:0]       servo_sum;
   logic [10:0]       servo_diff;
   logic [8:0]        pump_sum;

   // take the next action when the output register is free or draining
   assign pop = ~empty & (~rsp_valid_ff | ~rsp_stall);

   assign servo_sum  = {1'b0, servo_ff} + {3'b000, cfg.arm_stride};
   assign servo_diff = {1'b0, servo_ff} - {3'b000, cfg.arm_stride};
   assign pump_sum   = {1'b0, pump_ff} + {1'b0, cfg.pump_step};

   // actuator state update
   always_comb begin
      drive_in = drive_ff;
      servo_in = servo_ff;
      pump_in  = pump_ff;
      tick_in  = tick_ff;
      executed = 1'b0;
      if (pop) begin
         unique case (head.act)
            ACT_NONE: ;
            ACT_TICK: begin
               tick_in = (tick_ff == TICK_W'(PWM_PERIOD - 1)) ? '0 : tick_ff + 1'b1;
            end
            ACT_BRIDGE: begin
               drive_in = head.pattern;
               executed = 1'b1;
            end
            ACT_SERVO_UP: begin
               executed = 1'b1;
               if (servo_ff < cfg.servo_high) begin
                  servo_in = (servo_sum > {1'b0, cfg.servo_high}) ?
                             cfg.servo_high : servo_sum[9:0];
               end
            end
            ACT_SERVO_DOWN: begin
               executed = 1'b1;
               if (servo_ff > cfg.servo_low) begin
                  servo_in = (servo_diff[10] || (servo_diff[9:0] < cfg.servo_low)) ?
                             cfg.servo_low : servo_diff[9:0];
               end
            end
            ACT_PUMP_UP: begin
               executed = 1'b1;
               if (pump_ff != PUMP_MAX) begin
                  pump_in = pump_sum[8] ? PUMP_MAX : pump_sum[PUMP_W-1:0];
               end
            end
            ACT_PUMP_DOWN: begin
               executed = 1'b1;
               pump_in  = (cfg.pump_step >= pump_ff) ? '0 : pump_ff - cfg.pump_step;
            end
            ACT_UNKNOWN: executed = 1'b1;
            default: ;
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      if (pop) begin
         rsp_valid_in          = 1'b1;
         rsp_in.bridge_pattern = drive_in;
         rsp_in.servo_duty     = servo_in;
         rsp_in.pump_level     = pump_in;
         rsp_in.pump_gate      = GATE_CMP_W'(tick_in) < GATE_CMP_W'(pump_in);
         rsp_in.frame_executed = executed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff     <= PAT_STOP;
         servo_ff     <= SERVO_RESET;
         pump_ff      <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         drive_ff     <= drive_in;
         servo_ff     <= servo_in;
         pump_ff      <= pump_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a tick never reports a completed frame
   a_tick_no_exec: assert property (@(posedge clock) disable iff (reset)
      (pop && head.act == ACT_TICK) |=> !rsp_ff.frame_executed)
      else $error("tick reported as executed frame");

   // pwm counter stays inside its period
   a_tick_range: assert property (@(posedge clock) disable iff (reset)
      tick_ff <= TICK_W'(PWM_PERIOD - 1))
      else $error("pwm counter out of range");

   // pump gate in the result matches the stored duty and counter
   a_gate_match: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_ff.pump_gate == (GATE_CMP_W'(tick_ff) < GATE_CMP_W'(pump_ff))))
      else $error("pump gate mismatch");

endmodule

### rtl/framed_command_actuator_controller_core.sv
// ----------------------------------------------------------------------------
// framed_command_actuator_controller_core
// Parses framed serial commands and pwm ticks and drives the bridge, servo
// and pump outputs, one result transfer per input transfer.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload      handshake
//   req_      in         req_type     req_valid / req_stall
//   rsp_      out        rsp_type     rsp_valid / rsp_stall
//   csr       in/out     32-bit apb   psel / penable / pready
//
// one item per cycle while req_stall is low; a result passes from its input
// transfer through a queue slot, then the output register
// the two-entry queue lets the parser keep taking items while a result waits
// reset is synchronous and returns registers and actuator state to defaults
// req_stall rises only when the queue is full, which needs rsp_stall held
// ----------------------------------------------------------------------------
module framed_command_actuator_controller_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  fcac_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output fcac_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fcac_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fcac_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fcac_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import fcac_pkg::*;

   cfg_type   cfg;
   entry_type push_entry;
   entry_type head;
   logic      push;
   logic      pop;
   logic      empty;
   logic      full;

   // configuration registers
   fcac_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // frame parser
   fcac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (full),
      .push       (push),
      .entry      (push_entry)
   );

   // action queue
   fcac_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   // actuator back end
   fcac_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
